// File: src/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and character classification for the strict
// Base64 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64d_pkg;

	localparam int COUNT_BITS = 16;
	localparam int CNT_W      = (COUNT_BITS < 16) ? COUNT_BITS : 16;
	localparam int Q_DEPTH    = 4;
	localparam int Q_AW       = $clog2(Q_DEPTH);

	typedef logic [CNT_W-1:0] cnt_t;
	localparam cnt_t CNT_MAX = {CNT_W{1'b1}};

	localparam logic [7:0] CH_PAD = 8'h3D;

	typedef enum logic [2:0] {
		CL_SYM,
		CL_WS,
		CL_TRIM,
		CL_PAD,
		CL_BAD
	} cls_kind_t;

	typedef struct packed {
		cls_kind_t   kind;
		logic [5:0]  val;
	} cls_t;

	typedef enum logic [2:0] {
		PH_LEAD,
		PH_DATA,
		PH_TRAIL,
		PH_TRAIL0,
		PH_DONE,
		PH_ERR
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_MALFORMED = 2'd1,
		ST_LENGTH    = 2'd2
	} status_t;

	// one accepted character worth of results
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      nbytes;
		cnt_t            base;
		logic            last;
		status_t         status;
	} job_t;

	function automatic cls_t classify(input logic [7:0] c);
		cls_t r;
		r.kind = CL_BAD;
		r.val  = '0;
		if (c[7]) begin
			r.kind = CL_BAD;
		end else if (c >= 8'h41 && c <= 8'h5A) begin
			r.kind = CL_SYM;
			r.val  = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r.kind = CL_SYM;
			r.val  = 6'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r.kind = CL_SYM;
			r.val  = 6'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B) begin
			r.kind = CL_SYM;
			r.val  = 6'd62;
		end else if (c == 8'h2F) begin
			r.kind = CL_SYM;
			r.val  = 6'd63;
		end else if (c == 8'h09 || c == 8'h20) begin
			r.kind = CL_WS;
		end else if (c == 8'h0A || c == 8'h0D || c == 8'h2D) begin
			r.kind = CL_TRIM;
		end else if (c == CH_PAD) begin
			r.kind = CL_PAD;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: src/b64d_in_if.sv
// ----------------------------------------------------------------------------
// b64d_in_if
// Character channel: valid/ready with one character and a last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface b64d_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       in_last;

	modport source (output valid, in_char, in_last, input ready);
	modport sink (input valid, in_char, in_last, output ready);
endinterface

`default_nettype wire

// File: src/b64d_out_if.sv
// ----------------------------------------------------------------------------
// b64d_out_if
// Result channel: valid/ready with a decoded byte, status and byte count.
// ----------------------------------------------------------------------------
`default_nettype none

interface b64d_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic [1:0]  status;
	logic [15:0] decoded_count;
	logic        result_last;

	modport source (output valid, out_byte, byte_valid, status, decoded_count, result_last,
		input ready);
	modport sink (input valid, out_byte, byte_valid, status, decoded_count, result_last,
		output ready);
endinterface

`default_nettype wire

// File: src/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, classifies them, runs the decode state machine and
// pushes one job per character that produces results.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_front
	import b64d_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	b64d_in_if.sink     in_ch,
	output logic        push,
	output job_t        push_job,
	input  wire         q_full
);

	phase_t       phase_q, phase_n;
	logic [17:0]  hold_q, hold_n;
	logic [1:0]   slot_q, slot_n;
	logic [1:0]   len_q, len_n;
	logic [1:0]   tail_q, tail_n;
	cnt_t         total_q;
	cnt_t         total_n;
	cls_t         cls;
	logic         trim;
	logic         accept;
	logic [1:0]   nbytes;
	logic [2:0][7:0] bytes;
	status_t      st;
	logic [CNT_W:0] sum;
	logic [23:0]  word;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && in_ch.ready;

	always_comb begin
		cls     = classify(in_ch.in_char);
		trim    = (cls.kind == CL_WS) || (cls.kind == CL_TRIM);
		phase_n = phase_q;
		hold_n  = hold_q;
		slot_n  = slot_q;
		len_n   = len_q;
		tail_n  = tail_q;
		nbytes  = 2'd0;
		bytes   = '0;
		word    = {hold_q, cls.val};
		st      = ST_OK;

		case (phase_q)
			PH_LEAD: begin
				if (cls.kind != CL_WS) begin
					slot_n = 2'd0;
					len_n  = 2'd1;
					tail_n = 2'd0;
					if (trim) begin
						phase_n = PH_TRAIL0;
						tail_n  = 2'd1;
					end else if (cls.kind == CL_BAD || cls.kind == CL_PAD) begin
						phase_n = PH_ERR;
					end else begin
						phase_n = PH_DATA;
						hold_n  = {12'd0, cls.val};
						slot_n  = 2'd1;
					end
				end
			end
			PH_DATA: begin
				len_n = len_q + 2'd1;
				if (cls.kind == CL_BAD) begin
					phase_n = PH_ERR;
				end else if (trim) begin
					phase_n = PH_TRAIL;
					tail_n  = 2'd1;
				end else if (cls.kind == CL_PAD) begin
					if (slot_q == 2'd2) begin
						nbytes   = 2'd1;
						bytes[0] = hold_q[11:4];
						phase_n  = PH_DONE;
						tail_n   = 2'd0;
					end else if (slot_q == 2'd3) begin
						nbytes   = 2'd2;
						bytes[0] = hold_q[17:10];
						bytes[1] = hold_q[9:2];
						phase_n  = PH_DONE;
						tail_n   = 2'd0;
					end else begin
						phase_n = PH_ERR;
					end
				end else if (slot_q == 2'd3) begin
					nbytes   = 2'd3;
					bytes[0] = word[23:16];
					bytes[1] = word[15:8];
					bytes[2] = word[7:0];
					hold_n   = '0;
					slot_n   = 2'd0;
				end else begin
					hold_n = {hold_q[11:0], cls.val};
					slot_n = slot_q + 2'd1;
				end
			end
			PH_TRAIL, PH_TRAIL0: begin
				len_n = len_q + 2'd1;
				if (trim) begin
					tail_n = tail_q + 2'd1;
				end else begin
					phase_n = PH_ERR;
				end
			end
			PH_DONE: begin
				len_n = len_q + 2'd1;
				if (in_ch.in_char[7]) begin
					phase_n = PH_ERR;
				end else if (trim) begin
					tail_n = tail_q + 2'd1;
				end else begin
					tail_n = 2'd0;
				end
			end
			default: ;
		endcase

		if (phase_n == PH_ERR) begin
			st = ST_MALFORMED;
		end else if (phase_n == PH_LEAD) begin
			st = ST_OK;
		end else if (phase_n == PH_TRAIL0) begin
			st = ST_LENGTH;
		end else if ((len_n - tail_n) != 2'd0) begin
			st = ST_LENGTH;
		end

		sum     = {1'b0, total_q} + (CNT_W+1)'(nbytes);
		total_n = (sum > {1'b0, CNT_MAX}) ? CNT_MAX : sum[CNT_W-1:0];

		push            = accept && ((nbytes != 2'd0) || in_ch.in_last);
		push_job.bytes  = bytes;
		push_job.nbytes = nbytes;
		push_job.base   = total_q;
		push_job.last   = in_ch.in_last;
		push_job.status = in_ch.in_last ? st : ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			hold_q  <= '0;
			slot_q  <= '0;
			len_q   <= '0;
			tail_q  <= '0;
			total_q <= '0;
		end else if (accept) begin
			if (in_ch.in_last) begin
				phase_q <= PH_LEAD;
				hold_q  <= '0;
				slot_q  <= '0;
				len_q   <= '0;
				tail_q  <= '0;
				total_q <= '0;
			end else begin
				phase_q <= phase_n;
				hold_q  <= hold_n;
				slot_q  <= slot_n;
				len_q   <= len_n;
				tail_q  <= tail_n;
				total_q <= total_n;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// Small job queue between the decode front and the result back end.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_queue
	import b64d_pkg::*;
(
	input  wire    clk,
	input  wire    arst_n,
	input  wire    push,
	input  job_t   push_job,
	output logic   full,
	output logic   empty,
	input  wire    pop,
	output job_t   head
);

	job_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q;
	logic [Q_AW-1:0] rd_q;
	logic [Q_AW:0]   cnt_q;

	assign full  = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("pop from empty queue");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("queue count did not follow push");

endmodule

`default_nettype wire

// File: src/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Expands each queued job into one to three result transactions.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_back
	import b64d_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  job_t        head,
	input  wire         empty,
	output logic        pop,
	b64d_out_if.source  out_ch
);

	logic [1:0]     k_q;
	logic [1:0]     nres;
	logic           last_res;
	logic           accept;
	logic [CNT_W+1:0] sum;
	cnt_t           cnt;

	always_comb begin
		nres     = (head.nbytes == 2'd0) ? 2'd1 : head.nbytes;
		last_res = (k_q == nres - 2'd1);
		sum      = {2'b00, head.base} + (CNT_W+2)'(k_q) + (CNT_W+2)'(1);
		if (head.nbytes == 2'd0) begin
			cnt = head.base;
		end else if (sum > {2'b00, CNT_MAX}) begin
			cnt = CNT_MAX;
		end else begin
			cnt = sum[CNT_W-1:0];
		end

		out_ch.valid         = !empty;
		out_ch.byte_valid    = (head.nbytes != 2'd0);
		out_ch.out_byte      = out_ch.byte_valid ? head.bytes[k_q] : 8'd0;
		out_ch.decoded_count = 16'(cnt);
		out_ch.result_last   = head.last && last_res;
		out_ch.status        = out_ch.result_last ? head.status : ST_OK;

		accept = out_ch.valid && out_ch.ready;
		pop    = accept && last_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (accept) begin
			k_q <= last_res ? 2'd0 : k_q + 2'd1;
		end
	end

	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (k_q < nres))
		else $error("result index beyond job");

	a_last_pops: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ready && out_ch.result_last) |-> pop)
		else $error("final result did not retire its job");

	a_k_restart: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (k_q == 2'd0))
		else $error("result index not cleared after job");

endmodule

`default_nettype wire

// File: src/base64_decoder_strict.sv
// ----------------------------------------------------------------------------
// base64_decoder_strict
// Streaming strict Base64 decoder, one character per transaction in.
// ----------------------------------------------------------------------------
// The block accepts one character every cycle while its four-entry job queue
// has room, and delivers one result per cycle while the receiver is ready.
// Jobs pass through the registered queue in order. A quartet gives three
// byte results, a padded group one or two, and the last character of a message
// gives the final result carrying status and byte count (as the last byte
// result, or as a byte-less result of its own). No character ever needs more
// results on average than the port delivers: well-formed data yields three per
// four characters, so with a ready receiver the input runs at full rate and the
// result port stays about three quarters busy. The input stalls only once the
// receiver has held off long enough for the queue to fill.
// No clearing pass after reset. Bytes sent before an error stand; the
// consumer drops them when the final status is nonzero.
`default_nettype none

module base64_decoder_strict
	import b64d_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	b64d_in_if.sink     in_ch,
	b64d_out_if.source  out_ch
);

	logic push;
	job_t push_job;
	logic q_full;
	logic q_empty;
	logic pop;
	job_t head;

	b64d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.push     (push),
		.push_job (push_job),
		.q_full   (q_full)
	);

	b64d_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.empty    (q_empty),
		.pop      (pop),
		.head     (head)
	);

	b64d_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (q_empty),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule

`default_nettype wire
